// ===== hdl/kmds_pkg.sv =====
package kmds_pkg;

  localparam int COL_W   = 4;
  localparam int BITS_W  = 8;
  localparam int TIME_W  = 32;
  localparam int ROW_W   = 3;
  localparam int DEB_W   = 10;
  localparam int MAX_ROWS = 8;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 10'd5;

  typedef enum logic {
    EV_PRESS   = 1'b0,
    EV_RELEASE = 1'b1
  } ev_kind_t;

  // one row of one column on its way to the time memory
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [TIME_W-1:0] now;
    logic              pressed;
    logic              last_row;
  } kmds_req_t;

  // outcome of one row, handed to the event queue
  typedef struct packed {
    logic             has_ev;
    ev_kind_t         kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_row;
  } kmds_row_t;

endpackage

// ===== hdl/key_matrix_debounce_scanner_top.sv =====
// path: a row's memory read is registered into the decide stage; an event found there waits in
//   the queue's hold register for the next event or the item's final row, and is then registered
//   onto out_tvalid once the output is free
// throughput: one row a cycle through the single read port of the time memory unless a full
//   event queue stalls it; the next item is taken while results still drain
// reset: rst_n synchronous, active low; clears all sent-press flags and sets debounce_ms to 5
module key_matrix_debounce_scanner_top #(
  parameter int ROWS    = 8,
  parameter int COLUMNS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // scan input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // scan_column[3:0], row_bits[11:4], now_ms[43:12], zero
  // key events
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // key_row[2:0], key_column[6:3], zero
  output logic        out_tuser,  // event_kind
  output logic        out_tlast,  // last_event
  // configuration
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata   // debounce_ms
);
  import kmds_pkg::*;

  localparam int EFF_ROWS = (ROWS < MAX_ROWS) ? ROWS : MAX_ROWS;
  localparam int DEPTH    = EFF_ROWS * COLUMNS;
  localparam int ADDR_W   = $clog2(DEPTH > 1 ? DEPTH : 2);

  // debounce interval register
  logic [DEB_W-1:0] debounce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_r <= cfg_wdata;
    end
  end

  // row sequencer: walks a column's rows, one RAM read a cycle unless the decide stage stalls
  logic              adv, issue;
  kmds_req_t         seq_req;
  logic [ADDR_W-1:0] seq_addr;

  kmds_scan_seq #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .ADDR_W  (ADDR_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_col   (in_tdata[3:0]),
    .in_bits  (in_tdata[11:4]),
    .in_now   (in_tdata[43:12]),
    .adv      (adv),
    .issue    (issue),
    .req      (seq_req),
    .addr     (seq_addr)
  );

  // decide stage: memory data arrives here, the entry is updated and, if pressed, written back
  logic              s2_v_r, s2_v_nxt;
  kmds_req_t         s2_req_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic              s2_go;

  // sent-press flags live in flops so that reset clears them at once
  logic [DEPTH-1:0]  ps_r, ps_nxt;

  logic              ram_we;
  logic [TIME_W-1:0] ram_rdata;
  logic              fwd_hit_r;
  logic [TIME_W-1:0] fwd_data_r;
  logic [TIME_W-1:0] last_time, due;
  logic              sent, is_press, is_release;
  kmds_row_t         s2_row;

  assign adv = !s2_v_r || s2_go;

  always_comb begin
    s2_v_nxt = s2_v_r;
    if (s2_go) begin
      s2_v_nxt = 1'b0;
    end
    if (issue) begin
      s2_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_req_r  <= seq_req;
      s2_addr_r <= seq_addr;
      // the entry being written this cycle is the one now read: take the new time
      fwd_hit_r  <= ram_we && (s2_addr_r == seq_addr);
      fwd_data_r <= s2_req_r.now;
    end
  end

  // only pressed keys refresh their time
  assign ram_we = s2_go && s2_req_r.pressed;

  kmds_ram #(
    .WIDTH (TIME_W),
    .DEPTH (DEPTH)
  ) u_time_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s2_addr_r),
    .wdata (s2_req_r.now),
    .re    (issue),
    .raddr (seq_addr),
    .rdata (ram_rdata)
  );

  assign sent       = ps_r[s2_addr_r];
  assign last_time  = fwd_hit_r ? fwd_data_r : ram_rdata;
  // wraps at 32 bits, then a plain unsigned compare
  assign due        = last_time + {{(TIME_W - DEB_W){1'b0}}, debounce_r};
  assign is_press   = s2_req_r.pressed && !sent;
  assign is_release = !s2_req_r.pressed && sent && (due <= s2_req_r.now);

  always_comb begin
    ps_nxt = ps_r;
    if (s2_go && is_press) begin
      ps_nxt[s2_addr_r] = 1'b1;
    end
    if (s2_go && is_release) begin
      ps_nxt[s2_addr_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= '0;
    end else begin
      ps_r <= ps_nxt;
    end
  end

  assign s2_row.has_ev   = is_press || is_release;
  assign s2_row.kind     = is_release ? EV_RELEASE : EV_PRESS;
  assign s2_row.row      = s2_req_r.row;
  assign s2_row.col      = s2_req_r.col;
  assign s2_row.last_row = s2_req_r.last_row;

  // event queue: holds one event back to mark the last of each item
  ev_kind_t         ev_kind;
  logic [ROW_W-1:0] ev_row;
  logic [COL_W-1:0] ev_col;

  kmds_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (s2_v_r),
    .in_row    (s2_row),
    .go        (s2_go),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (ev_kind),
    .out_row   (ev_row),
    .out_col   (ev_col),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, ev_col, ev_row};
  assign out_tuser = ev_kind;

  a_issue_fills: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> s2_v_r)
    else $error("row read issued but decide stage empty");

  a_press_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && is_press) |=> ps_r[$past(s2_addr_r)])
    else $error("sent-press flag not set after press transfer");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && is_release) |=> !ps_r[$past(s2_addr_r)])
    else $error("sent-press flag still set after release");

  a_write_needs_row: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (s2_v_r && s2_req_r.pressed))
    else $error("time memory written without a pressed row");

endmodule

// ===== hdl/kmds_ram.sv =====
module kmds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/kmds_scan_seq.sv =====
module kmds_scan_seq #(
  parameter int ROWS    = 8,
  parameter int COLUMNS = 16,
  parameter int ADDR_W  = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kmds_pkg::COL_W-1:0]    in_col,
  input  logic [kmds_pkg::BITS_W-1:0]   in_bits,
  input  logic [kmds_pkg::TIME_W-1:0]   in_now,
  input  logic                          adv,
  output logic                          issue,
  output kmds_pkg::kmds_req_t           req,
  output logic [ADDR_W-1:0]             addr
);
  import kmds_pkg::*;

  localparam int EFF_ROWS = (ROWS < MAX_ROWS) ? ROWS : MAX_ROWS;
  localparam int ROW_CW   = (EFF_ROWS > 1) ? $clog2(EFF_ROWS) : 1;
  localparam logic [ROW_CW-1:0] LAST_ROW = ROW_CW'(EFF_ROWS - 1);

  logic              seq_v_r, seq_v_nxt;
  logic [ROW_CW-1:0] row_r, row_nxt;
  logic [COL_W-1:0]  col_r;
  logic [BITS_W-1:0] bits_r;
  logic [TIME_W-1:0] now_r;
  logic              accept, col_ok, done;

  assign issue    = seq_v_r && adv;
  assign done     = issue && (row_r == LAST_ROW);
  assign in_ready = !seq_v_r || done;
  assign accept   = in_valid && in_ready;
  // columns past the matrix are taken and dropped
  assign col_ok   = ({{(32 - COL_W){1'b0}}, in_col} < 32'(COLUMNS));

  always_comb begin
    seq_v_nxt = seq_v_r;
    row_nxt   = row_r;
    if (issue) begin
      row_nxt = row_r + 1'b1;
    end
    if (done) begin
      seq_v_nxt = 1'b0;
    end
    if (accept) begin
      seq_v_nxt = col_ok;
      row_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_v_r <= 1'b0;
      row_r   <= '0;
    end else begin
      seq_v_r <= seq_v_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r  <= in_col;
      bits_r <= in_bits;
      now_r  <= in_now;
    end
  end

  assign req.row      = ROW_W'(row_r);
  assign req.col      = col_r;
  assign req.now      = now_r;
  assign req.pressed  = bits_r[row_r];
  assign req.last_row = (row_r == LAST_ROW);
  assign addr = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(COLUMNS)) + ADDR_W'(col_r);

endmodule

// ===== hdl/kmds_evq.sv =====
module kmds_evq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_v,
  input  kmds_pkg::kmds_row_t          in_row,
  output logic                         go,
  output logic                         out_valid,
  input  logic                         out_ready,
  output kmds_pkg::ev_kind_t           out_kind,
  output logic [kmds_pkg::ROW_W-1:0]   out_row,
  output logic [kmds_pkg::COL_W-1:0]   out_col,
  output logic                         out_last
);
  import kmds_pkg::*;

  // one event is held back until it is known whether it closes its item
  logic             hold_v_r, hold_v_nxt;
  logic             hold_last_r, hold_last_nxt;
  ev_kind_t         hold_kind_r;
  logic [ROW_W-1:0] hold_row_r;
  logic [COL_W-1:0] hold_col_r;
  logic             out_v_r, out_v_nxt;
  logic             out_free, push, take;

  assign out_free = !out_v_r || out_ready;
  assign push = hold_v_r && out_free && (hold_last_r || (in_v && in_row.has_ev));
  assign go   = in_v && (!in_row.has_ev || !hold_v_r || out_free);
  assign take = go && in_row.has_ev;

  always_comb begin
    hold_v_nxt    = hold_v_r;
    hold_last_nxt = hold_last_r;
    if (push) begin
      hold_v_nxt = 1'b0;
    end
    if (take) begin
      hold_v_nxt    = 1'b1;
      hold_last_nxt = in_row.last_row;
    end else if (go && in_row.last_row) begin
      hold_last_nxt = 1'b1;
    end
    out_v_nxt = out_v_r;
    if (out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (push) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      hold_last_r <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      hold_v_r    <= hold_v_nxt;
      hold_last_r <= hold_last_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_kind_r <= in_row.kind;
      hold_row_r  <= in_row.row;
      hold_col_r  <= in_row.col;
    end
    if (push) begin
      out_kind <= hold_kind_r;
      out_row  <= hold_row_r;
      out_col  <= hold_col_r;
      out_last <= hold_last_r;
    end
  end

  assign out_valid = out_v_r;

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid)
    else $error("queued event not presented");

  a_take_holds: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> hold_v_r)
    else $error("event lost on entry to hold stage");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && out_v_r && !out_ready && in_v && in_row.has_ev) |-> !go)
    else $error("row retired while held event blocked");

endmodule
